// File: sv/sscs_pkg.sv
`timescale 1ns / 1ps
// Package for the seven-segment charlieplex scanner: shared types, segment
// patterns and the pin table. No dependencies.
package sscs_pkg;

    localparam int MAX_DIGITS  = 3;
    localparam int SEG_COUNT   = 7;
    localparam int PIN_ENTRIES = MAX_DIGITS * SEG_COUNT;
    localparam int PIN_IDX_W   = 5;

    localparam logic [3:0] DASH_CODE = 4'd10;

    typedef logic [PIN_IDX_W-1:0] pin_idx_t;

    // Digits as latched at frame start, position 0 leftmost.
    typedef struct packed {
        logic [MAX_DIGITS-1:0][3:0] digits;
        logic [1:0]                 count;
        logic                       out_of_range;
    } sscs_frame_t;

    typedef struct packed {
        logic       common_select;
        logic [3:0] sink_line;
        logic [1:0] digit_position;
        logic [2:0] segment_index;
        logic       out_of_range;
        logic       frame_end;
    } sscs_result_t;

    // Bit s lights segment s (0=a 1=f 2=e 3=d 4=c 5=b 6=g).
    localparam logic [6:0] SEG_MASK [16] = '{
        7'h3F, 7'h30, 7'h6D, 7'h79, 7'h72, 7'h5B, 7'h5F, 7'h31,
        7'h7F, 7'h7B, 7'h40, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam logic PIN_COMMON [PIN_ENTRIES] = '{
        1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
        1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
        1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1
    };

    localparam logic [3:0] PIN_SINK [PIN_ENTRIES] = '{
        4'd4,  4'd4,  4'd5,  4'd3,  4'd3,  4'd6,  4'd5,
        4'd7,  4'd7,  4'd8,  4'd9,  4'd9,  4'd6,  4'd8,
        4'd11, 4'd11, 4'd12, 4'd10, 4'd10, 4'd13, 4'd12
    };

    localparam logic [1:0] PIN_POS [PIN_ENTRIES] = '{
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2
    };

    localparam logic [2:0] PIN_SEG [PIN_ENTRIES] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6
    };

endpackage

// File: sv/sscs_value_if.sv
`timescale 1ns / 1ps
// Channel carrying one display slot item with the value to show.
// No dependencies.
interface sscs_value_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] show_value;

    modport source (output valid, output show_value, input ready);
    modport sink   (input valid, input show_value, output ready);
endinterface

// File: sv/sscs_segment_if.sv
`timescale 1ns / 1ps
// Channel carrying one lit-segment item per display slot.
// No dependencies.
interface sscs_segment_if;
    logic       valid;
    logic       ready;
    logic       common_select;
    logic [3:0] sink_line;
    logic [1:0] digit_position;
    logic [2:0] segment_index;
    logic       out_of_range;
    logic       frame_end;

    modport source (output valid, output common_select, output sink_line,
                    output digit_position, output segment_index,
                    output out_of_range, output frame_end, input ready);
    modport sink   (input valid, input common_select, input sink_line,
                    input digit_position, input segment_index,
                    input out_of_range, input frame_end, output ready);
endinterface

// File: sv/sscs_decode.sv
`timescale 1ns / 1ps
// Splits a value into left-aligned decimal digits, or dashes when out of range.
// Depends on sscs_pkg.
module sscs_decode
    import sscs_pkg::*;
#(
    parameter int DIGIT_COUNT = 3
)
(
    input  logic signed [15:0] value,
    output sscs_frame_t        frame
);

    localparam int LIMIT = 10 ** DIGIT_COUNT;

    logic        too_big;
    logic [9:0]  v;
    logic [15:0] prod_h;
    logic [20:0] prod_t;
    logic [3:0]  hundreds;
    logic [6:0]  by_ten;
    logic [3:0]  tens;
    logic [3:0]  ones;

    always_comb
    begin
        too_big = value[15] || (value[14:0] >= 15'(LIMIT));
        v       = value[9:0];

        // Reciprocal multiplies, exact for values below 1000.
        prod_h   = 16'(v) * 16'd41;
        hundreds = prod_h[15:12];
        prod_t   = 21'(v) * 21'd205;
        by_ten   = prod_t[17:11];
        tens     = 4'(by_ten - 7'(hundreds) * 7'd10);
        ones     = 4'(v - 10'(by_ten) * 10'd10);

        frame = '0;
        if (too_big)
        begin
            frame.out_of_range = 1'b1;
            frame.count        = 2'(DIGIT_COUNT);
            for (int p = 0; p < MAX_DIGITS; p++)
            begin
                frame.digits[p] = DASH_CODE;
            end
        end
        else if (v >= 10'd100)
        begin
            frame.count     = 2'd3;
            frame.digits[0] = hundreds;
            frame.digits[1] = tens;
            frame.digits[2] = ones;
        end
        else if (v >= 10'd10)
        begin
            frame.count     = 2'd2;
            frame.digits[0] = tens;
            frame.digits[1] = ones;
        end
        else
        begin
            frame.count     = 2'd1;
            frame.digits[0] = ones;
        end
    end

endmodule

// File: sv/sscs_scan.sv
`timescale 1ns / 1ps
// Scan state and lit-segment search: latches a frame, picks the segment for
// the current slot and the next one. Depends on sscs_pkg.
module sscs_scan
    import sscs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  sscs_frame_t  frame,
    output sscs_result_t result
);

    logic [MAX_DIGITS-1:0][3:0] store_reg, store_eff;
    logic [1:0]                 count_reg, count_eff;
    logic                       range_reg, range_eff;
    logic [1:0]                 scan_digit_reg, scan_digit_next;
    logic [2:0]                 scan_segment_reg, scan_segment_next;

    logic                   latch;
    pin_idx_t               start, total;
    logic [PIN_ENTRIES-1:0] lit, rest;
    pin_idx_t               cur, nxt;
    logic                   last;

    function automatic pin_idx_t first_set(input logic [PIN_ENTRIES-1:0] vec);
        pin_idx_t idx;
        idx = '0;
        for (int k = PIN_ENTRIES - 1; k >= 0; k--)
        begin
            if (vec[k])
            begin
                idx = PIN_IDX_W'(k);
            end
        end
        return idx;
    endfunction

    always_comb
    begin
        latch     = (scan_digit_reg == 2'd0) && (scan_segment_reg == 3'd0);
        store_eff = latch ? frame.digits       : store_reg;
        count_eff = latch ? frame.count        : count_reg;
        range_eff = latch ? frame.out_of_range : range_reg;

        start = PIN_IDX_W'(scan_digit_reg) * PIN_IDX_W'(SEG_COUNT)
              + PIN_IDX_W'(scan_segment_reg);
        total = PIN_IDX_W'(count_eff) * PIN_IDX_W'(SEG_COUNT);

        for (int k = 0; k < PIN_ENTRIES; k++)
        begin
            lit[k] = SEG_MASK[store_eff[PIN_POS[k]]][PIN_SEG[k]]
                  && (PIN_IDX_W'(k) >= start) && (PIN_IDX_W'(k) < total);
        end

        // Drop the lowest lit segment to find the one after it.
        rest = lit & (lit - PIN_ENTRIES'(1));
        cur  = first_set(lit);
        nxt  = first_set(rest);
        last = (rest == '0);

        scan_digit_next   = last ? 2'd0 : PIN_POS[nxt];
        scan_segment_next = last ? 3'd0 : PIN_SEG[nxt];

        result.common_select  = PIN_COMMON[cur];
        result.sink_line      = PIN_SINK[cur];
        result.digit_position = PIN_POS[cur];
        result.segment_index  = PIN_SEG[cur];
        result.out_of_range   = range_eff;
        result.frame_end      = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg        <= '0;
            count_reg        <= 2'd1;
            range_reg        <= 1'b0;
            scan_digit_reg   <= 2'd0;
            scan_segment_reg <= 3'd0;
        end
        else if (step)
        begin
            store_reg        <= store_eff;
            count_reg        <= count_eff;
            range_reg        <= range_eff;
            scan_digit_reg   <= scan_digit_next;
            scan_segment_reg <= scan_segment_next;
        end
    end

endmodule

// File: sv/seven_segment_charlieplex_scanner_unit.sv
`timescale 1ns / 1ps
// Top level of the seven-segment charlieplex scanner: input register, decode,
// scan and result register. Depends on sscs_pkg, both channel interfaces,
// sscs_decode and sscs_scan.
//
//  channel       role    payload
//  value_chan    sink    show_value (16, signed): value shown, latched at frame start
//  segment_chan  source  common_select, sink_line, digit_position, segment_index,
//                        out_of_range, frame_end
//
// Each item gives exactly one result item: it is held in the input register,
// then decode and segment search run into the result register. One item per
// cycle is sustained while segment_chan is ready; the scan state update sets
// that rate. Reset clears the scan to the start of a frame showing 0.
// A stalled result holds in the result register while one more item waits
// in the input register; only then does value_chan drop ready.
module seven_segment_charlieplex_scanner_unit
    import sscs_pkg::*;
#(
    parameter int DIGIT_COUNT = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    sscs_value_if.sink            value_chan,
    sscs_segment_if.source        segment_chan
);

    logic               in_valid_reg;
    logic signed [15:0] value_reg;
    logic               out_valid_reg;
    sscs_result_t       result_reg;

    logic         advance;
    sscs_frame_t  frame;
    sscs_result_t result;

    // Move the held item on whenever the result register is free or emptying.
    assign advance          = in_valid_reg && (!out_valid_reg || segment_chan.ready);
    assign value_chan.ready = !in_valid_reg || advance;

    sscs_decode #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_decode (
        .value (value_reg),
        .frame (frame)
    );

    sscs_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .frame  (frame),
        .result (result)
    );

    // Input register: hold the value until the scan takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (value_chan.ready)
        begin
            in_valid_reg <= value_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (value_chan.valid && value_chan.ready)
        begin
            value_reg <= value_chan.show_value;
        end
    end

    // Result register: load on advance, clear once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (segment_chan.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign segment_chan.valid          = out_valid_reg;
    assign segment_chan.common_select  = result_reg.common_select;
    assign segment_chan.sink_line      = result_reg.sink_line;
    assign segment_chan.digit_position = result_reg.digit_position;
    assign segment_chan.segment_index  = result_reg.segment_index;
    assign segment_chan.out_of_range   = result_reg.out_of_range;
    assign segment_chan.frame_end      = result_reg.frame_end;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for seven_segment_charlieplex_scanner_unit: directed
// frames, then random values under random idling on both channels.
// Depends on sscs_pkg and the sscs_value_if / sscs_segment_if channels.
module tb;
    import sscs_pkg::*;

    // Segment numbering on the result channel: a, f, e, d, c, b, g.
    localparam logic [2:0] SEG_A = 3'd0;
    localparam logic [2:0] SEG_F = 3'd1;
    localparam logic [2:0] SEG_E = 3'd2;
    localparam logic [2:0] SEG_D = 3'd3;
    localparam logic [2:0] SEG_C = 3'd4;
    localparam logic [2:0] SEG_B = 3'd5;
    localparam logic [2:0] SEG_G = 3'd6;

    localparam int RANDOM_SLOTS  = 1600;
    localparam int PRINT_LIMIT   = 30;
    localparam int DRAIN_CYCLES  = 1000;
    localparam int SETTLE_CYCLES = 8;

    // Lit segments per digit code; bit s lights segment s. Code 10 is a dash.
    localparam logic [6:0] GLYPH [16] = '{
        7'h3F, 7'h30, 7'h6D, 7'h79, 7'h72, 7'h5B, 7'h5F, 7'h31,
        7'h7F, 7'h7B, 7'h40, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // Wiring of the charlieplexed display, indexed by position * 7 + segment.
    localparam logic PAD_COMMON [21] = '{
        1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
        1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
        1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1
    };
    localparam logic [3:0] PAD_SINK [21] = '{
        4'd4,  4'd4,  4'd5,  4'd3,  4'd3,  4'd6,  4'd5,
        4'd7,  4'd7,  4'd8,  4'd9,  4'd9,  4'd6,  4'd8,
        4'd11, 4'd11, 4'd12, 4'd10, 4'd10, 4'd13, 4'd12
    };

    // One row of the directed table: the value, whether the expected lit
    // segment is spelt out by hand, and that segment.
    typedef struct packed {
        logic signed [15:0] value;
        logic               typed;
        sscs_result_t       want;
    } slot_row_t;

    logic clk;
    logic rst_n;

    sscs_value_if   value_chan ();
    sscs_segment_if segment_chan ();

    seven_segment_charlieplex_scanner_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .value_chan   (value_chan),
        .segment_chan (segment_chan)
    );

    // Shadow of the display state: the latched frame and the scan pointer.
    logic [3:0] shown_digits [3];
    logic [1:0] shown_count;
    logic       shown_dashes;
    logic [1:0] next_pos;
    logic [2:0] next_seg;

    sscs_result_t expected_segments [$];
    slot_row_t    directed_rows [$];

    int  mismatches;
    int  slots_sent;
    int  segments_seen;
    int  frames_seen;
    int  dashed_frames;
    bit  idle_off;

    always #5 clk = ~clk;

    // Hold the run to a hard ceiling in case either channel locks up.
    initial
    begin
        #3_000_000;
        $display("tb NOT OK");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string field, input int got, input int want);
        if (got != want)
            note_mismatch($sformatf("segment %0d %s got %0d want %0d",
                                    segments_seen, field, got, want));
    endtask

    // First lit entry of the latched frame at or after index from, or -1.
    function automatic int first_lit(input int from, input int span);
        for (int k = from; k < span; k++)
            if (GLYPH[shown_digits[k / 7]][k % 7])
                return k;
        return -1;
    endfunction

    // Advance the shadow scan by one slot and return the segment it lights.
    function automatic sscs_result_t next_lit_segment(input logic signed [15:0] v);
        int           mag;
        int           span;
        int           lit_at;
        int           after;
        logic         closing;
        sscs_result_t r;
        // A scan pointer at the origin means this slot opens a frame: latch.
        if (next_pos == 2'd0 && next_seg == 3'd0)
        begin
            if (v < 0 || v > 999)
            begin
                shown_dashes = 1'b1;
                shown_count  = 2'd3;
                for (int p = 0; p < 3; p++)
                    shown_digits[p] = DASH_CODE;
            end
            else
            begin
                mag          = int'(v);
                shown_dashes = 1'b0;
                shown_count  = (mag >= 100) ? 2'd3 : (mag >= 10) ? 2'd2 : 2'd1;
                for (int p = 0; p < 3; p++)
                    shown_digits[p] = 4'd0;
                // Left-aligned: most significant digit on position 0.
                for (int p = int'(shown_count) - 1; p >= 0; p--)
                begin
                    shown_digits[p] = 4'(mag % 10);
                    mag = mag / 10;
                end
            end
        end
        span = int'(shown_count) * 7;
        if (span > 21)
            span = 21;
        lit_at = first_lit(int'(next_pos) * 7 + int'(next_seg), span);
        after  = -1;
        if (lit_at < 0)
        begin
            lit_at  = 0;
            closing = 1'b1;
        end
        else
        begin
            after   = first_lit(lit_at + 1, span);
            closing = (after < 0);
        end
        if (closing)
        begin
            next_pos = 2'd0;
            next_seg = 3'd0;
        end
        else
        begin
            next_pos = 2'(after / 7);
            next_seg = 3'(after % 7);
        end
        r.common_select  = PAD_COMMON[lit_at];
        r.sink_line      = PAD_SINK[lit_at];
        r.digit_position = 2'(lit_at / 7);
        r.segment_index  = 3'(lit_at % 7);
        r.out_of_range   = shown_dashes;
        r.frame_end      = closing;
        return r;
    endfunction

    // Offer one slot item from a falling edge, wait for the handshake, then
    // queue what it should light. Leaves the caller on a falling edge.
    task automatic send_slot(input logic signed [15:0] v, input logic typed,
                             input sscs_result_t want);
        int           gap;
        sscs_result_t guess;
        gap = idle_off ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            value_chan.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        value_chan.valid      <= 1'b1;
        value_chan.show_value <= v;
        do
            @(posedge clk);
        while (!value_chan.ready);
        guess = next_lit_segment(v);
        expected_segments.push_back(typed ? want : guess);
        slots_sent++;
        @(negedge clk);
    endtask

    // Result side: stall at random, take each lit segment on a rising edge
    // and compare it with the oldest expectation.
    initial
    begin : segment_sink
        int           stall;
        sscs_result_t want;
        segment_chan.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            // Every third stretch of 120 segments runs with no back-pressure.
            stall = ((segments_seen / 120) % 3 == 1) ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                segment_chan.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            segment_chan.ready <= 1'b1;
            do
                @(posedge clk);
            while (!segment_chan.valid);
            if (expected_segments.size() == 0)
            begin
                note_mismatch($sformatf("segment %0d arrived with nothing expected",
                                        segments_seen));
            end
            else
            begin
                want = expected_segments.pop_front();
                compare_field("common_select", segment_chan.common_select,
                              want.common_select);
                compare_field("sink_line", segment_chan.sink_line, want.sink_line);
                compare_field("digit_position", segment_chan.digit_position,
                              want.digit_position);
                compare_field("segment_index", segment_chan.segment_index,
                              want.segment_index);
                compare_field("out_of_range", segment_chan.out_of_range,
                              want.out_of_range);
                compare_field("frame_end", segment_chan.frame_end, want.frame_end);
            end
            if (segment_chan.frame_end)
            begin
                frames_seen++;
                if (segment_chan.out_of_range)
                    dashed_frames++;
            end
            segments_seen++;
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int                 drain;
        int                 pick;
        logic signed [15:0] v;
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        value_chan.valid      = 1'b0;
        value_chan.show_value = '0;
        mismatches            = 0;
        slots_sent            = 0;
        segments_seen         = 0;
        frames_seen           = 0;
        dashed_frames         = 0;
        idle_off              = 1'b0;

        // Shadow state after reset: a frame showing 0, scan at the origin.
        for (int p = 0; p < 3; p++)
            shown_digits[p] = 4'd0;
        shown_count  = 2'd1;
        shown_dashes = 1'b0;
        next_pos     = 2'd0;
        next_seg     = 3'd0;

        // Directed frames. The value is only latched on the first slot of a
        // frame; the rest of the rows repeat it so the table reads by frame.
        // Zero straight after reset: a single 0 on position 0.
        directed_rows.push_back({16'sd0, 1'b1, {1'b1, 4'd4, 2'd0, SEG_A, 1'b0, 1'b0}});
        directed_rows.push_back({16'sd0, 1'b1, {1'b0, 4'd4, 2'd0, SEG_F, 1'b0, 1'b0}});
        directed_rows.push_back({16'sd0, 1'b1, {1'b0, 4'd5, 2'd0, SEG_E, 1'b0, 1'b0}});
        directed_rows.push_back({16'sd0, 1'b1, {1'b0, 4'd3, 2'd0, SEG_D, 1'b0, 1'b0}});
        directed_rows.push_back({16'sd0, 1'b1, {1'b1, 4'd3, 2'd0, SEG_C, 1'b0, 1'b0}});
        directed_rows.push_back({16'sd0, 1'b1, {1'b1, 4'd6, 2'd0, SEG_B, 1'b0, 1'b1}});
        // Minus one: a dash on each of the three positions.
        directed_rows.push_back({16'hFFFF, 1'b1, {1'b1, 4'd5, 2'd0, SEG_G, 1'b1, 1'b0}});
        directed_rows.push_back({16'hFFFF, 1'b1, {1'b0, 4'd8, 2'd1, SEG_G, 1'b1, 1'b0}});
        directed_rows.push_back({16'hFFFF, 1'b1, {1'b1, 4'd12, 2'd2, SEG_G, 1'b1, 1'b1}});
        // Field extremes and the first value too large, against the shadow.
        repeat (3) directed_rows.push_back({16'h7FFF, 1'b0, 12'd0});
        repeat (3) directed_rows.push_back({16'h8000, 1'b0, 12'd0});
        repeat (3) directed_rows.push_back({16'sd1000, 1'b0, 12'd0});
        // Fewest and most lit segments on a single digit.
        repeat (2) directed_rows.push_back({16'sd1, 1'b0, 12'd0});
        repeat (7) directed_rows.push_back({16'sd8, 1'b0, 12'd0});

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_slot(directed_rows[i].value, directed_rows[i].typed,
                      directed_rows[i].want);

        // Random values, weighted towards the display range so that one, two
        // and three digit frames dominate, with boundaries and raw noise mixed in.
        for (int n = 0; n < RANDOM_SLOTS; n++)
        begin
            idle_off = ((n / 100) % 4 == 3);
            pick = $urandom_range(0, 9);
            case (pick)
                0:       v = 16'($urandom_range(0, 9));
                1, 2:    v = 16'($urandom_range(10, 99));
                3, 4, 5: v = 16'($urandom_range(100, 999));
                6:
                begin
                    case ($urandom_range(0, 7))
                        0:       v = 16'sd0;
                        1:       v = 16'sd9;
                        2:       v = 16'sd10;
                        3:       v = 16'sd99;
                        4:       v = 16'sd100;
                        5:       v = 16'sd999;
                        6:       v = 16'sd1000;
                        default: v = 16'hFFFF;
                    endcase
                end
                default: v = 16'($urandom);
            endcase
            send_slot(v, 1'b0, 12'd0);
        end
        value_chan.valid <= 1'b0;

        // Drain: wait for the outstanding segments, then let the pipeline settle.
        drain = 0;
        while (expected_segments.size() != 0 && drain < DRAIN_CYCLES)
        begin
            @(posedge clk);
            drain++;
        end
        if (expected_segments.size() != 0)
            note_mismatch($sformatf("%0d expected segments never arrived",
                                    expected_segments.size()));
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("slots driven %0d (directed %0d), segments checked %0d",
                 slots_sent, directed_rows.size(), segments_seen);
        $display("frames closed %0d, of which dashed %0d, mismatches %0d",
                 frames_seen, dashed_frames, mismatches);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// File: files.f
sv/sscs_pkg.sv
sv/sscs_value_if.sv
sv/sscs_segment_if.sv
sv/sscs_decode.sv
sv/sscs_scan.sv
sv/seven_segment_charlieplex_scanner_unit.sv
test/tb.sv
